// ----- rtl/sse_pkg.sv -----
// ----------------------------------------------------------------------------
// sse_pkg
// shared codes, widths and parameter defaults of the sorted set engine
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int unsigned DefaultCapacity  = 256;
  localparam int unsigned DefaultValueBits = 32;

  // fixed widths of the item fields
  localparam int unsigned CmdW    = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned RankW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 9;

  typedef logic [CmdW-1:0]    cmd_t;
  typedef logic [StatusW-1:0] status_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_ERASE  = 2'd1;
  localparam cmd_t CMD_MEMBER = 2'd2;
  localparam cmd_t CMD_RANK   = 2'd3;

  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_NOT_DONE = 2'd1;
  localparam status_t ST_FULL     = 2'd2;

endpackage

// ----- rtl/sse_req_if.sv -----
// ----------------------------------------------------------------------------
// sse_req_if
// command channel: valid/ready handshake carrying one command item
// ----------------------------------------------------------------------------
interface sse_req_if;
  import sse_pkg::*;

  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [ValueW-1:0] item_value;
  logic [RankW-1:0]  rank;

  modport source (output valid, command, item_value, rank, input ready);
  modport sink   (input valid, command, item_value, rank, output ready);
endinterface

// ----- rtl/sse_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sse_rsp_if
// result channel: valid/ready handshake carrying one result item
// ----------------------------------------------------------------------------
interface sse_rsp_if;
  import sse_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [ValueW-1:0] read_value;
  logic [CountW-1:0] count;

  modport source (output valid, status, read_value, count, input ready);
  modport sink   (input valid, status, read_value, count, output ready);
endinterface

// ----- rtl/sorted_set_engine_core.sv -----
// ----------------------------------------------------------------------------
// sorted_set_engine_core
// steps: a rank read checks the rank against the count, then reads the entry; a
//   test runs a binary search, then decides; an insert or erase that changes the
//   set then moves entries one by one through a read state and a write state
// throughput: one item at a time, taken when idle; unread results stall the engine
// reset: synchronous, empties the set; memory contents are not cleared
// ----------------------------------------------------------------------------
module sorted_set_engine_core #(
  parameter int unsigned CAPACITY   = sse_pkg::DefaultCapacity,
  parameter int unsigned VALUE_BITS = sse_pkg::DefaultValueBits
) (
  input logic   clk,
  input logic   rst,
  sse_req_if.sink   req,
  sse_rsp_if.source rsp
);
  import sse_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1; // entry index
  localparam int unsigned CW = $clog2(CAPACITY + 1);                   // count width
  localparam int unsigned RW = AW + RankW;                             // rank compare

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH     = 4'd1;
  localparam logic [3:0] S_SCMP     = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_INS      = 4'd4;
  localparam logic [3:0] S_INS_WR   = 4'd5;
  localparam logic [3:0] S_ERS      = 4'd6;
  localparam logic [3:0] S_ERS_WR   = 4'd7;
  localparam logic [3:0] S_RANK_RD  = 4'd8;
  localparam logic [3:0] S_RANK_GET = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  // value store, largest first, entries below count are live
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rdata;
  logic [AW-1:0]         raddr;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;

  // control registers
  logic [3:0]    state;
  logic [CW-1:0] count;
  logic          out_valid;

  // working registers of the current item
  cmd_t                  cmd;
  logic [VALUE_BITS-1:0] val;
  logic [RankW-1:0]      rank_r;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         hi;
  logic [AW-1:0]         mid_r;
  logic                  found;
  logic [CW-1:0]         k;
  status_t               res_status;
  logic [VALUE_BITS-1:0] res_value;

  // result register
  status_t           out_status;
  logic [ValueW-1:0] out_value;
  logic [CountW-1:0] out_count;

  // midpoint of the open search window [lo, hi)
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid;
  logic [RW-1:0] rank_ext;
  logic          rank_ok;

  assign mid_sum  = ({1'b0, lo} + {1'b0, hi}) >> 1;
  assign mid      = AW'(mid_sum);
  assign rank_ext = RW'(rank_r);
  assign rank_ok  = rank_ext < RW'(count);

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_value = out_value;
  assign rsp.count      = out_count;

  // read address and write port chosen by the sequencer
  always_comb begin
    raddr = mid;
    we    = 1'b0;
    waddr = AW'(k);
    wdata = rdata;
    case (state)
      S_INS: begin
        raddr = AW'(k - CW'(1));
        if (!(k > lo)) begin
          // shifting done, drop the new value into its slot
          we    = 1'b1;
          waddr = AW'(lo);
          wdata = val;
        end
      end
      S_INS_WR: we = 1'b1;
      S_ERS:    raddr = AW'(k + CW'(1));
      S_ERS_WR: we = 1'b1;
      S_RANK_RD: raddr = AW'(rank_ext);
      default: raddr = mid;
    endcase
  end

  // single memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // the result register is refilled or held in the hand-over state
      if (rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd    <= req.command;
            val    <= VALUE_BITS'(req.item_value);
            rank_r <= req.rank;
            lo     <= '0;
            hi     <= count;
            found  <= 1'b0;
            state  <= (req.command == CMD_RANK) ? S_RANK_RD : S_SRCH;
          end
        end
        // binary search for the first entry not above the value
        S_SRCH: begin
          mid_r <= mid;
          state <= (lo < hi) ? S_SCMP : S_DECIDE;
        end
        S_SCMP: begin
          if (rdata > val) begin
            lo <= CW'(mid_r) + CW'(1);
          end else begin
            hi <= CW'(mid_r);
          end
          // values are distinct, so a hit lands exactly on the final slot
          if (rdata == val) begin
            found <= 1'b1;
          end
          state <= S_SRCH;
        end
        S_DECIDE: begin
          res_value <= '0;
          case (cmd)
            CMD_INSERT: begin
              if (found) begin
                res_status <= ST_NOT_DONE;
                state      <= S_DONE;
              end else if (count >= CW'(CAPACITY)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                k     <= count;
                state <= S_INS;
              end
            end
            CMD_ERASE: begin
              if (found) begin
                k     <= lo;
                state <= S_ERS;
              end else begin
                res_status <= ST_NOT_DONE;
                state      <= S_DONE;
              end
            end
            default: begin
              res_status <= found ? ST_DONE : ST_NOT_DONE;
              state      <= S_DONE;
            end
          endcase
        end
        // open a gap: move entries down one place, from the tail
        S_INS: begin
          if (k > lo) begin
            state <= S_INS_WR;
          end else begin
            count      <= count + CW'(1);
            res_status <= ST_DONE;
            state      <= S_DONE;
          end
        end
        S_INS_WR: begin
          k     <= k - CW'(1);
          state <= S_INS;
        end
        // close the gap: move entries up one place, from the hole
        S_ERS: begin
          if ({1'b0, k} + (CW+1)'(1) < {1'b0, count}) begin
            state <= S_ERS_WR;
          end else begin
            count      <= count - CW'(1);
            res_status <= ST_DONE;
            state      <= S_DONE;
          end
        end
        S_ERS_WR: begin
          k     <= k + CW'(1);
          state <= S_ERS;
        end
        S_RANK_RD: begin
          if (rank_ok) begin
            state <= S_RANK_GET;
          end else begin
            res_status <= ST_NOT_DONE;
            res_value  <= '0;
            state      <= S_DONE;
          end
        end
        S_RANK_GET: begin
          res_status <= ST_DONE;
          res_value  <= rdata;
          state      <= S_DONE;
        end
        // hand the item over once the result register is free
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_value  <= ValueW'(res_value);
            out_count  <= CountW'(count);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- test/sorted_set_engine_core_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_set_engine_core_tb
// self-checking bench for the descending sorted set engine: a driver pushes
// insert, erase, membership and rank-read items from a prepared queue, a
// shadow set predicts every result at acceptance, and a monitor checks the
// result items in order, with random idling on both channels
// ----------------------------------------------------------------------------
module sorted_set_engine_core_tb;
  import sse_pkg::*;

  localparam int unsigned Capacity   = DefaultCapacity;
  localparam int unsigned ValueBits  = DefaultValueBits;
  localparam int unsigned TargetCmds = 1500;
  // a full insert or erase moves up to 255 entries, plus the search; after the
  // last result wait out this settle time for stray results
  localparam int unsigned SettleCycles = 700;
  // watchdog limit, set well above the slowest run
  localparam longint unsigned TimeLimit = 100_000_000;
  localparam logic [ValueW-1:0] ValueMask = {ValueW{1'b1}} >> (ValueW - ValueBits);

  typedef struct packed {
    cmd_t              command;
    logic [ValueW-1:0] item_value;
    logic [RankW-1:0]  rank;
  } set_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [ValueW-1:0] read_value;
    logic [CountW-1:0] count;
  } set_reply_t;

  // shadow of the store: entries 0 .. used-1, largest first
  typedef struct packed {
    logic [CountW-1:0]                  used;
    logic [Capacity-1:0][ValueW-1:0]    vals;
  } set_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sse_req_if req ();
  sse_rsp_if rsp ();

  sorted_set_engine_core uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // driven copies, known from time zero
  logic     drv_valid  = 1'b0;
  set_cmd_t drv_cmd    = '0;
  logic     take_ready = 1'b0;

  assign req.valid      = drv_valid;
  assign req.command    = drv_cmd.command;
  assign req.item_value = drv_cmd.item_value;
  assign req.rank       = drv_cmd.rank;
  assign rsp.ready      = take_ready;

  set_cmd_t   pending_cmds[$];
  set_reply_t expected_replies[$];
  set_state_t plan_set;   // used while building the stimulus
  set_state_t model_set;  // advanced as the block accepts items

  int unsigned cmds_accepted = 0;
  int unsigned replies_seen  = 0;
  int unsigned fails         = 0;
  int unsigned full_seen     = 0;
  int unsigned peak_count    = 0;

  // one command applied to a set: search for the first entry not above the
  // value, then shift entries for an insert or erase
  function automatic set_reply_t apply_set_cmd(inout set_state_t s, input set_cmd_t c);
    set_reply_t        r;
    logic [ValueW-1:0] v;
    int unsigned       slot;
    int unsigned       k;
    logic              hit;
    v            = c.item_value & ValueMask;
    r.status     = ST_NOT_DONE;
    r.read_value = '0;
    slot = 0;
    while (slot < s.used && s.vals[slot] > v) slot++;
    hit = (slot < s.used) && (s.vals[slot] == v);
    case (c.command)
      CMD_INSERT: begin
        // duplicate check wins over the full check
        if (hit) begin
          r.status = ST_NOT_DONE;
        end else if (s.used >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          for (k = s.used; k > slot; k--) s.vals[k] = s.vals[k-1];
          s.vals[slot] = v;
          s.used       = s.used + 1'b1;
          r.status     = ST_DONE;
        end
      end
      CMD_ERASE: begin
        if (hit) begin
          for (k = slot; k + 1 < s.used; k++) s.vals[k] = s.vals[k+1];
          s.used   = s.used - 1'b1;
          r.status = ST_DONE;
        end
      end
      CMD_MEMBER: begin
        if (hit) r.status = ST_DONE;
      end
      default: begin
        if (c.rank < s.used) begin
          r.read_value = s.vals[c.rank];
          r.status     = ST_DONE;
        end
      end
    endcase
    r.count = s.used;
    return r;
  endfunction

  // random idling, switched off for a long quiet stretch
  function automatic bit take_break(input int unsigned n);
    if (n >= 200 && n < 450) return 1'b0;
    return ($urandom_range(0, 99) < 20);
  endfunction

  function automatic logic [ValueW-1:0] pick_stored();
    return plan_set.vals[$urandom_range(0, plan_set.used - 1)];
  endfunction

  task automatic queue_cmd(input cmd_t c, input logic [ValueW-1:0] v,
                           input logic [RankW-1:0] rk);
    set_cmd_t item;
    item = '{command: c, item_value: v, rank: rk};
    void'(apply_set_cmd(plan_set, item));
    pending_cmds.push_back(item);
  endtask

  // empty the planned set, mostly by erasing stored values, with some noise
  task automatic drain_set();
    while (plan_set.used > 0) begin
      if ($urandom_range(0, 5) == 0)
        queue_cmd(cmd_t'($urandom_range(0, 3)), $urandom, RankW'($urandom_range(0, 255)));
      else
        queue_cmd(CMD_ERASE, pick_stored(), RankW'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // driver: prediction happens on the edge where the item is taken
  // ---------------------------------------------------------------------------
  set_cmd_t   next_cmd;
  logic       next_valid;
  set_reply_t next_reply;

  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else begin
      next_valid = drv_valid;
      next_cmd   = drv_cmd;
      if (drv_valid && req.ready) begin
        next_reply = apply_set_cmd(model_set, drv_cmd);
        expected_replies.push_back(next_reply);
        cmds_accepted++;
        next_valid = 1'b0;
      end
      // a new item may follow at once; valid stays high then
      if (!next_valid && pending_cmds.size() > 0 && !take_break(cmds_accepted)) begin
        next_cmd   = pending_cmds.pop_front();
        next_valid = 1'b1;
      end
      drv_valid <= next_valid;
      drv_cmd   <= next_cmd;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result item against the oldest prediction
  // ---------------------------------------------------------------------------
  set_reply_t want;

  always @(posedge clk) begin
    if (rst) begin
      take_ready <= 1'b0;
    end else begin
      if (rsp.valid && take_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result with nothing expected: status %0d read_value %h count %0d",
                 rsp.status, rsp.read_value, rsp.count);
          fails++;
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fails++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
            fails++;
          end
          if (rsp.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp.count);
            fails++;
          end
          if (want.status == ST_FULL) full_seen++;
          if (want.count > peak_count) peak_count = want.count;
        end
        replies_seen++;
      end
      take_ready <= !take_break(replies_seen);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  cmd_t              rnd_cmd;
  logic [ValueW-1:0] rnd_value;
  logic [ValueW-1:0] pool_base;
  logic [RankW-1:0]  rnd_rank;
  int unsigned       phase_kind;
  int unsigned       phase_len;
  int unsigned       sel;
  bit                filled;

  initial begin
    plan_set  = '0;
    model_set = '0;
    filled    = 1'b0;

    // directed: empty store, extreme values and ranks, duplicates, misses
    queue_cmd(CMD_RANK,   '0, '0);                // rank read of an empty store
    queue_cmd(CMD_MEMBER, '0, '0);                // test on an empty store
    queue_cmd(CMD_ERASE,  '0, '0);                // erase of a missing value
    queue_cmd(CMD_INSERT, '0, '0);
    queue_cmd(CMD_INSERT, '1, '0);
    queue_cmd(CMD_INSERT, 32'h8000_0000, 8'hFF);
    queue_cmd(CMD_INSERT, '0, '0);                // duplicate insert
    queue_cmd(CMD_MEMBER, '1, '0);
    queue_cmd(CMD_MEMBER, 32'h0000_0001, '0);     // absent value
    queue_cmd(CMD_RANK,   '0, 8'd0);
    queue_cmd(CMD_RANK,   '0, 8'd2);
    queue_cmd(CMD_RANK,   '1, 8'd3);              // rank just past the count
    queue_cmd(CMD_RANK,   '0, 8'hFF);
    queue_cmd(CMD_ERASE,  32'h8000_0000, '0);
    queue_cmd(CMD_ERASE,  32'h8000_0000, '0);     // erase again, now missing
    queue_cmd(CMD_ERASE,  '1, 8'hFF);
    queue_cmd(CMD_ERASE,  '0, '0);
    queue_cmd(CMD_RANK,   '0, '0);

    // random phases: churn around a value pool, drains, and one fill to capacity
    while (pending_cmds.size() < TargetCmds) begin
      phase_kind = $urandom_range(0, 9);
      if (!filled && pending_cmds.size() >= 600) phase_kind = 9;
      if (phase_kind == 9 && !filled) begin
        filled = 1'b1;
        while (plan_set.used < Capacity) begin
          if ($urandom_range(0, 7) == 0)
            queue_cmd(CMD_RANK, $urandom, RankW'($urandom_range(0, 255)));
          else
            queue_cmd(CMD_INSERT, $urandom, RankW'($urandom_range(0, 255)));
        end
        // full store: new values bounce, duplicates report not done
        repeat (16) begin
          case ($urandom_range(0, 3))
            0:       queue_cmd(CMD_INSERT, $urandom, '0);
            1:       queue_cmd(CMD_INSERT, pick_stored(), '0);
            2:       queue_cmd(CMD_RANK, $urandom, RankW'($urandom_range(0, 255)));
            default: queue_cmd(CMD_MEMBER, pick_stored(), '0);
          endcase
        end
        queue_cmd(CMD_RANK, '0, 8'hFF);
        queue_cmd(CMD_ERASE, pick_stored(), '0);
        queue_cmd(CMD_INSERT, $urandom, '0);
        queue_cmd(CMD_INSERT, $urandom, '0);
        drain_set();
      end else if (phase_kind >= 7) begin
        drain_set();
      end else begin
        phase_len = $urandom_range(20, 60);
        pool_base = $urandom;
        repeat (phase_len) begin
          rnd_cmd = cmd_t'($urandom_range(0, 3));
          if (rnd_cmd == CMD_INSERT && plan_set.used > 40 && $urandom_range(0, 1))
            rnd_cmd = CMD_ERASE;
          sel = $urandom_range(0, 9);
          if (sel < 4 && plan_set.used > 0)
            rnd_value = pick_stored();
          else if (sel < 8)
            rnd_value = pool_base + $urandom_range(0, 31);
          else if (sel == 8)
            rnd_value = $urandom;
          else
            rnd_value = $urandom_range(0, 1) ? '1 : '0;
          if ($urandom_range(0, 9) < 7)
            rnd_rank = RankW'($urandom_range(0, (plan_set.used > 255) ? 255 : plan_set.used));
          else
            rnd_rank = RankW'($urandom_range(0, 255));
          queue_cmd(rnd_cmd, rnd_value, rnd_rank);
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || drv_valid) @(posedge clk);
    while (expected_replies.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("%0d items sent, %0d results checked, %0d of them full-store rejections",
             cmds_accepted, replies_seen, full_seen);
    $display("set grew to %0d of %0d entries at its largest", peak_count, Capacity);
    if (fails == 0)
      $display("sorted_set_engine_core: match");
    else
      $display("sorted_set_engine_core: mismatch");
    $finish;
  end

  // watchdog
  initial begin
    #(TimeLimit);
    $display("sorted_set_engine_core: mismatch");
    $finish;
  end

endmodule
